// File: rtl/core/magnetometer_acquisition_sequencer_defines.svh
// Assertion macros used by the acquisition sequencer top level.
`ifndef MAGNETOMETER_ACQUISITION_SEQUENCER_DEFINES_SVH
`define MAGNETOMETER_ACQUISITION_SEQUENCER_DEFINES_SVH

// Same-cycle implication, sampled on clk, switched off during rst.
`define MAS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sequencer check failed");

// Next-cycle implication, sampled on clk, switched off during rst.
`define MAS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sequencer check failed");

`endif

// File: rtl/core/mas_pkg.sv
// Types, codes and defaults of the magnetometer acquisition sequencer.
package mas_pkg;

  localparam int CHECK_ENTRIES_DEF = 2;

  localparam int IN_DATA_W  = 128;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 184;
  localparam int OUT_USER_W = 5;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_PERIOD = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_WAIT      = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_READY_TIMEOUT = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_ERROR_LIMIT   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_CHECK_INTERVAL = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_CHECK_TABLE   = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_READY_MASK    = 3'd6;

  // register reset values
  localparam logic [19:0] SAMPLE_PERIOD_RST  = 20'd20000;
  localparam logic [19:0] MIN_WAIT_RST       = 20'd6000;
  localparam logic [19:0] READY_TIMEOUT_RST  = 20'd20000;
  localparam logic [7:0]  ERROR_LIMIT_RST    = 8'd3;
  localparam logic [15:0] CHECK_INTERVAL_RST = 16'd100;
  localparam logic [31:0] CHECK_TABLE_RST    = 32'd0;
  localparam logic [7:0]  READY_MASK_RST     = 8'd1;

  // opcodes
  localparam logic OP_STEP = 1'b0;
  localparam logic OP_INIT = 1'b1;

  // bus outcomes
  localparam logic [1:0] BUS_OK      = 2'd0;
  localparam logic [1:0] BUS_OVERRUN = 2'd2;

  // actions
  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_CHECK   = 3'd1;
  localparam logic [2:0] ACT_TRIGGER = 3'd2;
  localparam logic [2:0] ACT_STATUS  = 3'd3;
  localparam logic [2:0] ACT_MEASURE = 3'd4;

  // phases
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_TRIG  = 2'd1;
  localparam logic [1:0] PH_READY = 2'd2;

  localparam logic [7:0] CONSEC_MAX = 8'd255;

  typedef struct packed {
    logic [19:0] sample_period_us;
    logic [19:0] poll_delay_us;
    logic [19:0] ready_timeout_us;
    logic [7:0]  error_limit;
    logic [15:0] check_interval;
    logic [31:0] check_table;
    logic [7:0]  ready_mask;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic [63:0] trigger_time;
    logic [7:0]  consecutive_errors;
    logic [15:0] window_count;
    logic        check_pointer;
    logic        was_bound;
    logic        started_flag;
    logic        fault_flag;
    logic [31:0] sample_count;
    logic [31:0] error_count;
    logic [31:0] overrun_count;
    logic [31:0] mismatch_count;
  } state_t;

  typedef struct packed {
    logic               opcode;
    logic [63:0]        now_us;
    logic [1:0]         bus_status;
    logic [7:0]         read_byte;
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
    logic signed [15:0] raw_z;
  } item_t;

  typedef struct packed {
    logic [2:0]         action;
    logic               check_slot;
    logic               sample_out;
    logic signed [15:0] body_x;
    logic signed [15:0] body_y;
    logic signed [15:0] body_z;
    logic [31:0]        sample_total;
    logic [31:0]        error_total;
    logic [31:0]        overrun_total;
    logic [31:0]        mismatch_total;
    logic               fault;
    logic               started;
  } result_t;

endpackage

// File: rtl/core/mas_step.sv
// Next-state and result logic for one sequencer item.
module mas_step import mas_pkg::*; #(
  parameter int CHECK_ENTRIES = CHECK_ENTRIES_DEF
) (
  input  cfg_t    cfg,
  input  state_t  st,
  input  item_t   item,
  output state_t  st_next,
  output result_t res
);

  logic [63:0] elapsed;
  logic        bus_bad;
  logic        err;
  logic [15:0] window_inc;
  logic [7:0]  chk_mask;
  logic [7:0]  chk_expect;
  logic [7:0]  consec_inc;
  logic        ptr_adv;

  assign elapsed    = item.now_us - st.trigger_time;
  assign bus_bad    = (item.bus_status != BUS_OK);
  assign window_inc = st.window_count + 16'd1;
  assign chk_mask   = st.check_pointer ? cfg.check_table[23:16] : cfg.check_table[7:0];
  assign chk_expect = st.check_pointer ? cfg.check_table[31:24] : cfg.check_table[15:8];
  assign consec_inc = (st.consecutive_errors < CONSEC_MAX) ?
                      st.consecutive_errors + 8'd1 : st.consecutive_errors;
  // toggle between the two table entries; stays at entry 0 when CHECK_ENTRIES is 1
  assign ptr_adv    = (CHECK_ENTRIES > 1) ? ~st.check_pointer : 1'b0;

  always_comb begin
    st_next = st;
    err     = 1'b0;
    res     = '0;

    if (item.opcode == OP_INIT) begin
      st_next.was_bound = 1'b1;
      if (bus_bad) begin
        st_next.started_flag = 1'b0;
        if (st.was_bound) begin
          st_next.fault_flag = 1'b1;
        end
      end else begin
        st_next.fault_flag         = 1'b0;
        st_next.started_flag       = 1'b1;
        st_next.sample_count       = '0;
        st_next.trigger_time       = '0;
        st_next.phase              = PH_IDLE;
        st_next.window_count       = '0;
        st_next.check_pointer      = 1'b0;
        st_next.consecutive_errors = '0;
      end
    end else if (!st.fault_flag && st.started_flag) begin
      case (st.phase)
        PH_IDLE: begin
          if (elapsed >= {44'd0, cfg.sample_period_us}) begin
            if (window_inc >= cfg.check_interval) begin
              st_next.window_count = '0;
              res.action     = ACT_CHECK;
              res.check_slot = st.check_pointer;
              if (bus_bad) begin
                err = 1'b1;
              end else if ((item.read_byte & chk_mask) != chk_expect) begin
                st_next.mismatch_count = st.mismatch_count + 32'd1;
                st_next.fault_flag     = 1'b1;
              end else begin
                st_next.check_pointer = ptr_adv;
              end
            end else begin
              st_next.window_count = window_inc;
              res.action           = ACT_TRIGGER;
              st_next.trigger_time = item.now_us;
              if (bus_bad) begin
                err = 1'b1;
              end else begin
                st_next.phase = PH_TRIG;
              end
            end
          end
        end
        PH_TRIG: begin
          if (elapsed >= {44'd0, cfg.poll_delay_us}) begin
            res.action = ACT_STATUS;
            if (bus_bad) begin
              err           = 1'b1;
              st_next.phase = PH_IDLE;
            end else if ((item.read_byte & cfg.ready_mask) == 8'd0) begin
              if (elapsed > {44'd0, cfg.ready_timeout_us}) begin
                err           = 1'b1;
                st_next.phase = PH_IDLE;
              end
            end else begin
              st_next.phase = PH_READY;
            end
          end
        end
        PH_READY: begin
          res.action    = ACT_MEASURE;
          st_next.phase = PH_IDLE;
          if (item.bus_status == BUS_OVERRUN) begin
            st_next.overrun_count = st.overrun_count + 32'd1;
          end else if (bus_bad) begin
            err = 1'b1;
          end else begin
            res.sample_out             = 1'b1;
            res.body_x                 = item.raw_y;
            res.body_y                 = 16'sd0 - item.raw_x;
            res.body_z                 = 16'sd0 - item.raw_z;
            st_next.sample_count       = st.sample_count + 32'd1;
            st_next.consecutive_errors = '0;
          end
        end
        default: begin
          st_next.phase = PH_IDLE;
        end
      endcase

      if (err) begin
        st_next.error_count        = st.error_count + 32'd1;
        st_next.consecutive_errors = consec_inc;
        if (consec_inc >= cfg.error_limit) begin
          st_next.fault_flag = 1'b1;
        end
      end
    end

    res.sample_total   = st_next.sample_count;
    res.error_total    = st_next.error_count;
    res.overrun_total  = st_next.overrun_count;
    res.mismatch_total = st_next.mismatch_count;
    res.fault          = st_next.fault_flag;
    res.started        = st_next.started_flag;
  end

endmodule

// File: rtl/core/magnetometer_acquisition_sequencer.sv
// Top level of the magnetometer acquisition sequencer.
//
//  channel  dir  handshake            payload
//  s_axis   in   s_tvalid / s_tready  s_tuser opcode, s_tdata time, bus outcome, read byte, raw
//  m_axis   out  m_tvalid / m_tready  m_tuser action/slot/flag, m_tdata body sample, totals, flags
//  cfg      in   cfg_we               cfg_addr register index, cfg_wdata value
//
// One beat per cycle while m_tready holds high; a taken beat passes the input
// register, then the result register, before it shows on m_tvalid.
// Sequencer state updates as a beat moves from the input register to the
// result register, so the following beat always sees the updated state.
// rst is synchronous: it empties both registers, clears state and loads the
// register defaults.
// A stalled output holds the result register; the input register still takes
// one more beat before s_tready drops.
`include "magnetometer_acquisition_sequencer_defines.svh"

module magnetometer_acquisition_sequencer import mas_pkg::*; #(
  parameter int CHECK_ENTRIES = CHECK_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // s_tdata: now_us[63:0], bus_status[65:64], read_byte[73:66], raw_x[89:74],
  //          raw_y[105:90], raw_z[121:106], zero fill above
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // s_tuser: opcode[0]
  input  logic [IN_USER_W-1:0]  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // m_tdata: body_x[15:0], body_y[31:16], body_z[47:32], sample_total[79:48],
  //          error_total[111:80], overrun_total[143:112],
  //          mismatch_total[175:144], fault[176], started[177], zero fill above
  output logic [OUT_DATA_W-1:0] m_tdata,
  // m_tuser: action[2:0], check_slot[3], sample_out[4]
  output logic [OUT_USER_W-1:0] m_tuser,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t    cfg;
  state_t  st;
  state_t  st_next;
  item_t   item;
  logic    item_valid;
  result_t res_next;
  result_t res;
  logic    out_valid;
  logic    advance;
  logic    take;

  // The input register moves on when the result register is free or draining.
  assign advance  = item_valid && (!out_valid || m_tready);
  assign s_tready = !item_valid || advance;
  assign take     = s_tvalid && s_tready;

  // Configuration writes; an index past the list is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_period_us <= SAMPLE_PERIOD_RST;
      cfg.poll_delay_us    <= MIN_WAIT_RST;
      cfg.ready_timeout_us <= READY_TIMEOUT_RST;
      cfg.error_limit      <= ERROR_LIMIT_RST;
      cfg.check_interval   <= CHECK_INTERVAL_RST;
      cfg.check_table      <= CHECK_TABLE_RST;
      cfg.ready_mask       <= READY_MASK_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SAMPLE_PERIOD:  cfg.sample_period_us <= cfg_wdata[19:0];
        REG_MIN_WAIT:       cfg.poll_delay_us    <= cfg_wdata[19:0];
        REG_READY_TIMEOUT:  cfg.ready_timeout_us <= cfg_wdata[19:0];
        REG_ERROR_LIMIT:    cfg.error_limit      <= cfg_wdata[7:0];
        REG_CHECK_INTERVAL: cfg.check_interval   <= cfg_wdata[15:0];
        REG_CHECK_TABLE:    cfg.check_table      <= cfg_wdata;
        REG_READY_MASK:     cfg.ready_mask       <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Input register: unpack the beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.opcode     <= s_tuser[0];
      item.now_us     <= s_tdata[63:0];
      item.bus_status <= s_tdata[65:64];
      item.read_byte  <= s_tdata[73:66];
      item.raw_x      <= s_tdata[89:74];
      item.raw_y      <= s_tdata[105:90];
      item.raw_z      <= s_tdata[121:106];
    end
  end

  mas_step #(
    .CHECK_ENTRIES(CHECK_ENTRIES)
  ) u_step (
    .cfg    (cfg),
    .st     (st),
    .item   (item),
    .st_next(st_next),
    .res    (res_next)
  );

  // Commit the state together with the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = {res.sample_out, res.check_slot, res.action};
  assign m_tdata  = {6'd0, res.started, res.fault, res.mismatch_total, res.overrun_total,
                     res.error_total, res.sample_total, res.body_z, res.body_y, res.body_x};

  // A stalled result must keep the next beat parked in the input register.
  `MAS_ASSERT_NEXT(a_hold_input, item_valid && out_valid && !m_tready, item_valid)
  // A sample only comes with a measurement read.
  `MAS_ASSERT_NOW(a_sample_on_measure, out_valid && res.sample_out, res.action == ACT_MEASURE)
  // A check slot is reported only by a check read.
  `MAS_ASSERT_NOW(a_slot_on_check, out_valid && res.check_slot, res.action == ACT_CHECK)
  // Each emitted sample bumps the sample count by one and clears the error run.
  `MAS_ASSERT_NEXT(a_sample_count, advance && res_next.sample_out,
                   st.sample_count == $past(st.sample_count) + 32'd1 &&
                   st.consecutive_errors == 8'd0)

endmodule
